[hdl/pp_pkg.sv]
package pp_pkg;

  // default raster size
  localparam int unsigned SCREEN_WIDTH_DEF  = 160;
  localparam int unsigned SCREEN_HEIGHT_DEF = 44;

  // pixel index width that covers the largest supported raster (512 x 256)
  localparam int unsigned IDX_W = 17;

  // command queue depth between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // field widths
  localparam int unsigned COORD_W = 24;
  localparam int unsigned TRIG_W  = 16;
  localparam int unsigned OOZ_W   = 24;
  localparam int unsigned GLYPH_W = 8;
  localparam int unsigned ADDR_W  = 13;

  localparam logic [GLYPH_W-1:0] BLANK_GLYPH = 8'd32;
  localparam logic signed [30:0] NEAR_LIMIT  = 31'sd25;

  // input op codes
  localparam logic [1:0] OP_PLOT  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_COS_YAW   = 3'd0;
  localparam logic [2:0] CFG_SIN_YAW   = 3'd1;
  localparam logic [2:0] CFG_COS_PITCH = 3'd2;
  localparam logic [2:0] CFG_SIN_PITCH = 3'd3;
  localparam logic [2:0] CFG_CAMERA_X  = 3'd4;
  localparam logic [2:0] CFG_CAMERA_Y  = 3'd5;
  localparam logic [2:0] CFG_CAMERA_Z  = 3'd6;
  localparam logic [2:0] CFG_SCALE     = 3'd7;

  // configuration reset values
  localparam logic signed [15:0] COS_YAW_RST   = 16'sd16384;
  localparam logic signed [15:0] SIN_YAW_RST   = 16'sd0;
  localparam logic signed [15:0] COS_PITCH_RST = 16'sd14378;
  localparam logic signed [15:0] SIN_PITCH_RST = -16'sd7855;
  localparam logic signed [23:0] CAMERA_X_RST  = 24'sd0;
  localparam logic signed [23:0] CAMERA_Y_RST  = 24'sd7680;
  localparam logic signed [23:0] CAMERA_Z_RST  = -24'sd17920;
  localparam logic [15:0]        SCALE_RST     = 16'd10240;

  typedef enum logic [2:0] {
    ST_DRAWN     = 3'd0,
    ST_HIDDEN    = 3'd1,
    ST_OFFSCREEN = 3'd2,
    ST_NEAR      = 3'd3,
    ST_CLEARED   = 3'd4,
    ST_READ      = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CMD_PLOT  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // work item handed from front to back
  typedef struct packed {
    cmd_e                kind;
    status_e             status;
    logic [IDX_W-1:0]    idx;
    logic [OOZ_W-1:0]    ooz;
    logic [GLYPH_W-1:0]  glyph;
  } pp_cmd_t;

endpackage

[hdl/pp_front.sv]
module pp_front #(
  parameter int unsigned SCREEN_WIDTH  = pp_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = pp_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [2:0]               cfg_idx_i,
  input  logic [23:0]              cfg_data_i,
  input  logic                     init_done_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               op_i,
  input  logic signed [23:0]       world_x_i,
  input  logic signed [23:0]       world_y_i,
  input  logic signed [23:0]       world_z_i,
  input  logic [7:0]               glyph_i,
  input  logic [12:0]              pixel_address_i,
  output logic                     cmd_valid_o,
  input  logic                     cmd_ready_i,
  output pp_pkg::pp_cmd_t          cmd_o
);
  import pp_pkg::*;

  localparam int unsigned PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam logic signed [55:0] COL_BIAS = 56'(SCREEN_WIDTH * 32768);
  localparam logic signed [55:0] ROW_BIAS = 56'(SCREEN_HEIGHT * 32768);
  localparam logic signed [55:0] TRUNC_ADJ = 56'sd65535;

  typedef enum logic [3:0] {
    F_IDLE, F_MUL1, F_ROT1, F_MUL2, F_ROT2, F_DIV,
    F_MUL3, F_SHIFT, F_MUL4, F_FIN, F_IDX, F_PUSH
  } f_state_e;

  f_state_e state_q;

  // configuration registers
  logic signed [15:0] cos_yaw_q, sin_yaw_q, cos_pitch_q, sin_pitch_q;
  logic signed [23:0] cam_x_q, cam_y_q, cam_z_q;
  logic [15:0]        scale_q;

  // datapath registers
  logic signed [24:0] cx_q, cy_q, cz_q;
  logic signed [40:0] p1_q, p2_q, p3_q, p4_q;
  logic signed [27:0] tx_q, tz_q;
  logic signed [43:0] q1_q, q2_q, q3_q, q4_q;
  logic signed [30:0] ty_q, fz_q;
  logic [31:0]        rem_q;
  logic [28:0]        quo_q;
  logic [4:0]         cnt_q;
  logic signed [52:0] axp_q;
  logic signed [55:0] ayp_q;
  logic signed [32:0] ax_q;
  logic signed [35:0] ay_q;
  logic signed [49:0] sx_q;
  logic signed [52:0] sy_q;
  logic signed [39:0] col_q, row_q;
  logic [GLYPH_W-1:0] glyph_q;
  pp_cmd_t            cmd_q;

  // combinational helpers
  logic signed [41:0] yaw_x, yaw_z;
  logic signed [44:0] pitch_y, pitch_z;
  logic [31:0]        rem_sh;
  logic               rem_ge;
  logic signed [55:0] col_v, row_v;
  logic [IDX_W-1:0]   addr_ext;
  logic               addr_ok;
  logic               on_screen;
  logic [IDX_W-1:0]   pix_idx;

  assign in_ready_o  = (state_q == F_IDLE) && init_done_i;
  assign cmd_valid_o = (state_q == F_PUSH);
  assign cmd_o       = cmd_q;

  // rotation sums
  assign yaw_x   = 42'(p1_q) - 42'(p2_q);
  assign yaw_z   = 42'(p3_q) + 42'(p4_q);
  assign pitch_y = 45'(q1_q) - 45'(q2_q);
  assign pitch_z = 45'(q3_q) + 45'(q4_q);

  // one restoring divide step of 2^28 by the depth
  assign rem_sh = {rem_q[30:0], (cnt_q == 5'd28)};
  assign rem_ge = rem_sh >= {1'b0, fz_q};

  // screen position before truncation
  assign col_v = COL_BIAS + (56'(sx_q) <<< 1);
  assign row_v = ROW_BIAS - 56'(sy_q);

  // address check for clear and read
  assign addr_ext = IDX_W'(pixel_address_i);
  assign addr_ok  = addr_ext < IDX_W'(PIXELS);

  // raster bounds and pixel index
  assign on_screen = (col_q >= 0) && (col_q < 40'(SCREEN_WIDTH)) &&
                     (row_q >= 0) && (row_q < 40'(SCREEN_HEIGHT));
  assign pix_idx   = IDX_W'(col_q) + IDX_W'(row_q) * IDX_W'(SCREEN_WIDTH);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_yaw_q   <= COS_YAW_RST;
      sin_yaw_q   <= SIN_YAW_RST;
      cos_pitch_q <= COS_PITCH_RST;
      sin_pitch_q <= SIN_PITCH_RST;
      cam_x_q     <= CAMERA_X_RST;
      cam_y_q     <= CAMERA_Y_RST;
      cam_z_q     <= CAMERA_Z_RST;
      scale_q     <= SCALE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COS_YAW:   cos_yaw_q   <= cfg_data_i[15:0];
        CFG_SIN_YAW:   sin_yaw_q   <= cfg_data_i[15:0];
        CFG_COS_PITCH: cos_pitch_q <= cfg_data_i[15:0];
        CFG_SIN_PITCH: sin_pitch_q <= cfg_data_i[15:0];
        CFG_CAMERA_X:  cam_x_q     <= cfg_data_i;
        CFG_CAMERA_Y:  cam_y_q     <= cfg_data_i;
        CFG_CAMERA_Z:  cam_z_q     <= cfg_data_i;
        CFG_SCALE:     scale_q     <= cfg_data_i[15:0];
        default:       scale_q     <= scale_q;
      endcase
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            glyph_q <= glyph_i;
            cx_q    <= 25'(world_x_i) - 25'(cam_x_q);
            cy_q    <= 25'(world_y_i) - 25'(cam_y_q);
            cz_q    <= 25'(world_z_i) - 25'(cam_z_q);
            cmd_q.ooz   <= '0;
            cmd_q.glyph <= glyph_i;
            if (op_i == OP_PLOT) begin
              state_q <= F_MUL1;
            end else begin
              cmd_q.idx    <= addr_ok ? addr_ext : '0;
              cmd_q.status <= (op_i == OP_CLEAR) ? ST_CLEARED : ST_READ;
              if (!addr_ok) begin
                cmd_q.kind <= CMD_NONE;
              end else if (op_i == OP_CLEAR) begin
                cmd_q.kind <= CMD_CLEAR;
              end else begin
                cmd_q.kind <= CMD_READ;
              end
              state_q <= F_PUSH;
            end
          end
        end
        F_MUL1: begin
          p1_q    <= cx_q * cos_yaw_q;
          p2_q    <= cz_q * sin_yaw_q;
          p3_q    <= cx_q * sin_yaw_q;
          p4_q    <= cz_q * cos_yaw_q;
          state_q <= F_ROT1;
        end
        F_ROT1: begin
          tx_q    <= yaw_x[41:14];
          tz_q    <= yaw_z[41:14];
          state_q <= F_MUL2;
        end
        F_MUL2: begin
          q1_q    <= 44'(cy_q) * 44'(cos_pitch_q);
          q2_q    <= tz_q * sin_pitch_q;
          q3_q    <= 44'(cy_q) * 44'(sin_pitch_q);
          q4_q    <= tz_q * cos_pitch_q;
          state_q <= F_ROT2;
        end
        F_ROT2: begin
          ty_q <= pitch_y[44:14];
          fz_q <= pitch_z[44:14];
          if ($signed(pitch_z[44:14]) > NEAR_LIMIT) begin
            rem_q   <= '0;
            quo_q   <= '0;
            cnt_q   <= 5'd28;
            state_q <= F_DIV;
          end else begin
            cmd_q.kind   <= CMD_NONE;
            cmd_q.status <= ST_NEAR;
            cmd_q.idx    <= '0;
            state_q      <= F_PUSH;
          end
        end
        F_DIV: begin
          rem_q <= rem_ge ? (rem_sh - {1'b0, fz_q}) : rem_sh;
          quo_q <= {quo_q[27:0], rem_ge};
          cnt_q <= cnt_q - 5'd1;
          if (cnt_q == 5'd0) begin
            state_q <= F_MUL3;
          end
        end
        F_MUL3: begin
          cmd_q.ooz <= quo_q[OOZ_W-1:0];
          axp_q     <= tx_q * $signed({1'b0, quo_q[OOZ_W-1:0]});
          ayp_q     <= 56'(ty_q) * 56'($signed({1'b0, quo_q[OOZ_W-1:0]}));
          state_q   <= F_SHIFT;
        end
        F_SHIFT: begin
          ax_q    <= axp_q[52:20];
          ay_q    <= ayp_q[55:20];
          state_q <= F_MUL4;
        end
        F_MUL4: begin
          sx_q    <= $signed({1'b0, scale_q}) * ax_q;
          sy_q    <= $signed({1'b0, scale_q}) * ay_q;
          state_q <= F_FIN;
        end
        F_FIN: begin
          // truncate toward zero
          col_q   <= col_v[55] ? 40'((col_v + TRUNC_ADJ) >>> 16) : 40'(col_v >>> 16);
          row_q   <= row_v[55] ? 40'((row_v + TRUNC_ADJ) >>> 16) : 40'(row_v >>> 16);
          state_q <= F_IDX;
        end
        F_IDX: begin
          if (on_screen) begin
            cmd_q.kind   <= CMD_PLOT;
            cmd_q.status <= ST_DRAWN;
            cmd_q.idx    <= pix_idx;
          end else begin
            cmd_q.kind   <= CMD_NONE;
            cmd_q.status <= ST_OFFSCREEN;
            cmd_q.idx    <= '0;
          end
          cmd_q.glyph <= glyph_q;
          state_q     <= F_PUSH;
        end
        F_PUSH: begin
          if (cmd_ready_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  // a new item is taken only while nothing is in flight
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == F_IDLE))
    else $error("front ready outside idle");

  // plot commands carry a nonzero reciprocal depth
  a_plot_ooz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_o && cmd_q.kind == CMD_PLOT) |-> (cmd_q.ooz != '0))
    else $error("plot command with zero depth");

  // the divider finishes before projection
  a_div_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == F_DIV && cnt_q == 5'd0) |=> (state_q == F_MUL3))
    else $error("divider did not hand over");

endmodule

[hdl/pp_queue.sv]
module pp_queue #(
  parameter int unsigned DEPTH = pp_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  output logic            wr_ready_o,
  input  pp_pkg::pp_cmd_t wr_data_i,
  output logic            rd_valid_o,
  input  logic            rd_ready_i,
  output pp_pkg::pp_cmd_t rd_data_o
);
  import pp_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  pp_cmd_t          entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, pop;

  assign wr_ready_o = cnt_q != CNT_W'(DEPTH);
  assign rd_valid_o = cnt_q != '0;
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = entry_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("queue overfilled");

  a_cnt_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
    else $error("queue count lost a transfer");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with split pointers");

endmodule

[hdl/pp_back.sv]
module pp_back #(
  parameter int unsigned SCREEN_WIDTH  = pp_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = pp_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  output logic            init_done_o,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  pp_pkg::pp_cmd_t cmd_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [2:0]      status_o,
  output logic [12:0]     pixel_out_o,
  output logic [7:0]      glyph_out_o
);
  import pp_pkg::*;

  localparam int unsigned PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int unsigned MEM_AW = $clog2(PIXELS);
  localparam int unsigned ENTRY_W = OOZ_W + GLYPH_W;

  typedef enum logic [1:0] {B_CLR, B_IDLE, B_RMW, B_OUT} b_state_e;

  b_state_e state_q;

  // depth and glyph per pixel, depth in the upper bits
  logic [ENTRY_W-1:0] mem [PIXELS];
  logic [ENTRY_W-1:0] rd_q;
  logic [MEM_AW-1:0]  clr_q;
  pp_cmd_t            cur_q;
  status_e            status_q;
  logic [12:0]        pix_q;
  logic [GLYPH_W-1:0] glyph_q;

  logic               we;
  logic [MEM_AW-1:0]  waddr;
  logic [ENTRY_W-1:0] wdata;
  logic [MEM_AW-1:0]  raddr;
  logic               nearer;

  assign init_done_o = state_q != B_CLR;
  assign cmd_ready_o = state_q == B_IDLE;
  assign out_valid_o = state_q == B_OUT;
  assign status_o    = status_q;
  assign pixel_out_o = pix_q;
  assign glyph_out_o = glyph_q;

  assign raddr  = cmd_i.idx[MEM_AW-1:0];
  assign nearer = cur_q.ooz > rd_q[ENTRY_W-1:GLYPH_W];

  // memory write select
  always_comb begin
    we    = 1'b0;
    waddr = cur_q.idx[MEM_AW-1:0];
    wdata = {cur_q.ooz, cur_q.glyph};
    case (state_q)
      B_CLR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = {{OOZ_W{1'b0}}, BLANK_GLYPH};
      end
      B_IDLE: begin
        if (cmd_valid_i && cmd_i.kind == CMD_CLEAR) begin
          we    = 1'b1;
          waddr = raddr;
          wdata = {{OOZ_W{1'b0}}, BLANK_GLYPH};
        end
      end
      B_RMW: begin
        we = (cur_q.kind == CMD_PLOT) && nearer;
      end
      default: we = 1'b0;
    endcase
  end

  // glyph and depth store
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  // control and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_CLR;
      clr_q   <= '0;
    end else begin
      case (state_q)
        B_CLR: begin
          clr_q <= clr_q + MEM_AW'(1);
          if (clr_q == MEM_AW'(PIXELS - 1)) begin
            state_q <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (cmd_valid_i) begin
            cur_q    <= cmd_i;
            status_q <= cmd_i.status;
            pix_q    <= 13'(cmd_i.idx);
            case (cmd_i.kind)
              CMD_CLEAR: begin
                glyph_q <= BLANK_GLYPH;
                state_q <= B_OUT;
              end
              CMD_NONE: begin
                glyph_q <= '0;
                state_q <= B_OUT;
              end
              default: state_q <= B_RMW;
            endcase
          end
        end
        B_RMW: begin
          if (cur_q.kind == CMD_PLOT && nearer) begin
            status_q <= ST_DRAWN;
            glyph_q  <= cur_q.glyph;
          end else begin
            if (cur_q.kind == CMD_PLOT) begin
              status_q <= ST_HIDDEN;
            end
            glyph_q <= rd_q[GLYPH_W-1:0];
          end
          state_q <= B_OUT;
        end
        B_OUT: begin
          if (out_ready_i) begin
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  a_clr_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_CLR) |-> (!out_valid_o && !cmd_ready_o))
    else $error("activity during clearing pass");

  a_rmw_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_RMW) |=> out_valid_o)
    else $error("depth compare did not produce a result");

  a_clear_glyph: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_q == ST_CLEARED && pix_q != '0) |-> (glyph_q == BLANK_GLYPH))
    else $error("cleared pixel reports a glyph");

endmodule

[hdl/point_projection_zbuffer.sv]
// Perspective point projector with a depth-buffered glyph store. A plot item
// (tuser 0) is moved into camera space, rotated by yaw and pitch, divided by
// depth and mapped to a pixel; it wins the pixel when it is nearer than what
// is stored. Clear (tuser 1) blanks one pixel, read (tuser 2 or 3) returns it.
// Every item gives exactly one result. The front computes the projection of
// a plot mostly in the one-bit-per-cycle reciprocal divider (29 steps); clear
// and read skip the projection. The back takes one item at a time through the
// store's read-modify-write port. After reset a clearing pass writes every
// pixel, one per cycle, and no item is taken until it ends. Configuration
// writes land at once and must only happen while the block is idle.
module point_projection_zbuffer #(
  parameter int unsigned SCREEN_WIDTH  = pp_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = pp_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // world_x[23:0], world_y[47:24], world_z[71:48], glyph[79:72],
  // pixel_address[92:80], zero fill [95:93]
  input  logic [95:0] s_axis_tdata,
  // op[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel_out[12:0], glyph_out[20:13], zero fill [23:21]
  output logic [23:0] m_axis_tdata,
  // status[2:0]
  output logic [2:0]  m_axis_tuser
);
  import pp_pkg::*;

  logic        init_done;
  logic        fq_valid, fq_ready, qb_valid, qb_ready;
  pp_cmd_t     fq_cmd, qb_cmd;
  logic [12:0] pixel_out;
  logic [7:0]  glyph_out;

  pp_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .init_done_i     (init_done),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .op_i            (s_axis_tuser),
    .world_x_i       (s_axis_tdata[23:0]),
    .world_y_i       (s_axis_tdata[47:24]),
    .world_z_i       (s_axis_tdata[71:48]),
    .glyph_i         (s_axis_tdata[79:72]),
    .pixel_address_i (s_axis_tdata[92:80]),
    .cmd_valid_o     (fq_valid),
    .cmd_ready_i     (fq_ready),
    .cmd_o           (fq_cmd)
  );

  pp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_ready_o (fq_ready),
    .wr_data_i  (fq_cmd),
    .rd_valid_o (qb_valid),
    .rd_ready_i (qb_ready),
    .rd_data_o  (qb_cmd)
  );

  pp_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .init_done_o (init_done),
    .cmd_valid_i (qb_valid),
    .cmd_ready_o (qb_ready),
    .cmd_i       (qb_cmd),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_o    (m_axis_tuser),
    .pixel_out_o (pixel_out),
    .glyph_out_o (glyph_out)
  );

  assign m_axis_tdata = {3'b000, glyph_out, pixel_out};

endmodule
